>>> hw/rtl/lzwd_pkg.sv
`default_nettype none

package lzwd_pkg;

    localparam int BYTE_W = 8;
    localparam int WIN_AW = 11;
    localparam int WIN_DEPTH = 1 << WIN_AW;
    localparam int LEN_W = 5;
    localparam int GRP_BYTES = 4;
    localparam int GRP_IW = $clog2(GRP_BYTES);
    localparam int CNT_W = 3;
    localparam int REM_W = 4;

    localparam logic [CNT_W-1:0] CNT_LIT = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_COPY = CNT_W'(GRP_BYTES);
    localparam logic [REM_W-1:0] FLAGS_PER_BYTE = REM_W'(8);
    localparam logic [GRP_IW-1:0] GRP_LAST_IDX = GRP_IW'(GRP_BYTES - 1);

    // token parser phase
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_OFS_LO,
        PH_OFS_HI
    } phase_t;

    // copy sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } ctl_state_t;

    typedef struct packed {
        logic              lit;
        logic              copy;
        logic [WIN_AW-1:0] ofs;
        logic [LEN_W-1:0]  len_m1;
    } tok_t;

endpackage

`default_nettype wire

>>> hw/rtl/lzwd_parser.sv
`default_nettype none

module lzwd_parser (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [lzwd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                        chunk_last,
    output lzwd_pkg::tok_t                   tok
);

    lzwd_pkg::phase_t phase_reg, phase_next;
    logic [lzwd_pkg::BYTE_W-1:0] flag_bits_reg, flag_bits_next;
    logic [lzwd_pkg::REM_W-1:0] flags_rem_reg, flags_rem_next;
    logic [lzwd_pkg::REM_W-1:0] rem_m1;
    logic [lzwd_pkg::GRP_IW-1:0] lit_idx_reg, lit_idx_next;
    logic [lzwd_pkg::BYTE_W-1:0] ofs_lo_reg, ofs_lo_next;
    logic adv;

    assign rem_m1 = flags_rem_reg - lzwd_pkg::REM_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lzwd_pkg::PH_FLAG;
            flag_bits_reg <= '0;
            flags_rem_reg <= '0;
            lit_idx_reg   <= '0;
            ofs_lo_reg    <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            flag_bits_reg <= flag_bits_next;
            flags_rem_reg <= flags_rem_next;
            lit_idx_reg   <= lit_idx_next;
            ofs_lo_reg    <= ofs_lo_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        flag_bits_next = flag_bits_reg;
        flags_rem_next = flags_rem_reg;
        lit_idx_next   = lit_idx_reg;
        ofs_lo_next    = ofs_lo_reg;
        adv            = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                lzwd_pkg::PH_FLAG:
                begin
                    flag_bits_next = in_byte;
                    flags_rem_next = lzwd_pkg::FLAGS_PER_BYTE - lzwd_pkg::REM_W'(1);
                    lit_idx_next   = '0;
                    phase_next     = in_byte[lzwd_pkg::BYTE_W-1] ? lzwd_pkg::PH_OFS_LO
                                                                 : lzwd_pkg::PH_LIT;
                end
                lzwd_pkg::PH_LIT:
                begin
                    lit_idx_next = lit_idx_reg + lzwd_pkg::GRP_IW'(1);
                    adv          = (lit_idx_reg == lzwd_pkg::GRP_LAST_IDX);
                end
                lzwd_pkg::PH_OFS_LO:
                begin
                    ofs_lo_next = in_byte;
                    phase_next  = lzwd_pkg::PH_OFS_HI;
                end
                lzwd_pkg::PH_OFS_HI:
                begin
                    adv = 1'b1;
                end
                default:
                begin
                    phase_next = lzwd_pkg::PH_FLAG;
                end
            endcase
            if (adv)
            begin
                if (flags_rem_reg == '0)
                begin
                    phase_next = lzwd_pkg::PH_FLAG;
                end
                else
                begin
                    flags_rem_next = rem_m1;
                    lit_idx_next   = '0;
                    phase_next     = flag_bits_reg[rem_m1[2:0]] ? lzwd_pkg::PH_OFS_LO
                                                                : lzwd_pkg::PH_LIT;
                end
            end
            // end of chunk drops any partial group
            if (chunk_last)
            begin
                phase_next     = lzwd_pkg::PH_FLAG;
                flags_rem_next = '0;
                lit_idx_next   = '0;
            end
        end
    end

    // token decode of the current byte
    always_comb
    begin
        tok.lit    = (phase_reg == lzwd_pkg::PH_LIT);
        tok.copy   = (phase_reg == lzwd_pkg::PH_OFS_HI);
        tok.ofs    = {in_byte[2:0], ofs_lo_reg};
        tok.len_m1 = in_byte[lzwd_pkg::BYTE_W-1:3];
    end

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        flags_rem_reg <= lzwd_pkg::FLAGS_PER_BYTE)
        else $error("flag count out of range");

endmodule

`default_nettype wire

>>> hw/rtl/lz_window_decompressor.sv
// Flag bytes and low offset bytes: no beat out.
// Literal: its beat is in the output register the cycle after accept.
// Copy: 4 window reads per group through the registered memory read port, then a
// handoff of each 4-byte group to the output register, up to 32 groups; input stalls meanwhile.
// Reset clears control only; a write-position fill mark makes unwritten window bytes
// read as zero, so there is no clearing pass and the block is ready right after reset.
`default_nettype none

module lz_window_decompressor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lzwd_pkg::BYTE_W-1:0]    in_byte,
    input  wire logic                           chunk_last,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]         out_byte_0,
    output logic [lzwd_pkg::BYTE_W-1:0]         out_byte_1,
    output logic [lzwd_pkg::BYTE_W-1:0]         out_byte_2,
    output logic [lzwd_pkg::BYTE_W-1:0]         out_byte_3,
    output logic [lzwd_pkg::CNT_W-1:0]          byte_count,
    output logic                                last_of_run,
    output logic                                chunk_end
);

    lzwd_pkg::tok_t tok;
    lzwd_pkg::ctl_state_t state_reg, state_next;

    logic in_acc, lit_go, copy_go, issue, out_free, grp_move, we, fwd_now, src_written;
    logic issue_end;
    logic [lzwd_pkg::BYTE_W-1:0] wdata, copy_byte;

    logic [lzwd_pkg::BYTE_W-1:0] win_mem [lzwd_pkg::WIN_DEPTH];
    logic [lzwd_pkg::BYTE_W-1:0] mem_rdata_reg;

    logic [lzwd_pkg::WIN_AW-1:0] wp_reg, wp_next;
    logic wrapped_reg, wrapped_next;
    logic [lzwd_pkg::WIN_AW-1:0] src_reg, src_next;
    logic [lzwd_pkg::LEN_W-1:0] grp_left_reg, grp_left_next;
    logic [lzwd_pkg::GRP_IW-1:0] issue_idx_reg, issue_idx_next;
    logic chunk_reg, chunk_next;

    logic rd_vld_reg, rd_vld_next;
    logic [lzwd_pkg::GRP_IW-1:0] rd_idx_reg, rd_idx_next;
    logic rd_zero_reg, rd_zero_next;
    logic rd_last_reg, rd_last_next;
    logic fwd_hit_reg, fwd_hit_next;
    logic [lzwd_pkg::BYTE_W-1:0] fwd_data_reg, fwd_data_next;

    logic [lzwd_pkg::BYTE_W-1:0] grp_byte_reg [lzwd_pkg::GRP_BYTES];
    logic grp_full_reg, grp_full_next;
    logic grp_last_reg, grp_last_next;

    logic out_valid_reg, out_valid_next;
    logic [lzwd_pkg::BYTE_W-1:0] ob0_reg, ob1_reg, ob2_reg, ob3_reg;
    logic [lzwd_pkg::CNT_W-1:0] cnt_reg;
    logic run_last_reg, chunk_end_reg;

    lzwd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_acc),
        .in_byte    (in_byte),
        .chunk_last (chunk_last),
        .tok        (tok)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == lzwd_pkg::ST_IDLE) && out_free;
    assign in_acc   = in_valid && in_ready;
    assign lit_go   = in_acc && tok.lit;
    assign copy_go  = in_acc && tok.copy;

    // byte 0 of a group waits for the group buffer to drain
    assign issue = (state_reg == lzwd_pkg::ST_ISSUE)
                   && ((issue_idx_reg != '0) || (!grp_full_reg && !rd_vld_reg));
    assign issue_end = issue && (issue_idx_reg == lzwd_pkg::GRP_LAST_IDX);
    assign grp_move = grp_full_reg && out_free;

    assign copy_byte = fwd_hit_reg ? fwd_data_reg :
                       (rd_zero_reg ? '0 : mem_rdata_reg);
    assign we    = lit_go || rd_vld_reg;
    assign wdata = lit_go ? in_byte : copy_byte;

    // read and write of the same slot in the same cycle: take the write data
    assign fwd_now     = we && (wp_reg == src_reg);
    assign src_written = wrapped_reg || (src_reg < wp_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            win_mem[wp_reg] <= wdata;
        end
        if (issue)
        begin
            mem_rdata_reg <= win_mem[src_reg];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzwd_pkg::ST_IDLE:
            begin
                if (copy_go)
                begin
                    state_next = lzwd_pkg::ST_ISSUE;
                end
            end
            lzwd_pkg::ST_ISSUE:
            begin
                if (issue_end && (grp_left_reg == '0))
                begin
                    state_next = lzwd_pkg::ST_DRAIN;
                end
            end
            lzwd_pkg::ST_DRAIN:
            begin
                if (grp_move && grp_last_reg)
                begin
                    state_next = lzwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lzwd_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        wp_next        = we ? wp_reg + lzwd_pkg::WIN_AW'(1) : wp_reg;
        wrapped_next   = wrapped_reg || (we && (wp_reg == '1));
        src_next       = src_reg;
        grp_left_next  = grp_left_reg;
        chunk_next     = chunk_reg;
        issue_idx_next = issue ? issue_idx_reg + lzwd_pkg::GRP_IW'(1) : issue_idx_reg;
        if (copy_go)
        begin
            src_next       = wp_reg - tok.ofs;
            grp_left_next  = tok.len_m1;
            chunk_next     = chunk_last;
            issue_idx_next = '0;
        end
        else if (issue)
        begin
            src_next = src_reg + lzwd_pkg::WIN_AW'(1);
            if (issue_end && (grp_left_reg != '0))
            begin
                grp_left_next = grp_left_reg - lzwd_pkg::LEN_W'(1);
            end
        end

        rd_vld_next   = issue;
        rd_idx_next   = issue_idx_reg;
        rd_zero_next  = !src_written;
        rd_last_next  = (grp_left_reg == '0);
        fwd_hit_next  = issue && fwd_now;
        fwd_data_next = wdata;

        grp_full_next = grp_full_reg;
        grp_last_next = grp_last_reg;
        if (rd_vld_reg && (rd_idx_reg == lzwd_pkg::GRP_LAST_IDX))
        begin
            grp_full_next = 1'b1;
            grp_last_next = rd_last_reg;
        end
        else if (grp_move)
        begin
            grp_full_next = 1'b0;
        end

        if (lit_go || grp_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzwd_pkg::ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            grp_left_reg  <= '0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            grp_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            grp_left_reg  <= grp_left_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            fwd_hit_reg   <= fwd_hit_next;
            grp_full_reg  <= grp_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        chunk_reg    <= chunk_next;
        rd_idx_reg   <= rd_idx_next;
        rd_zero_reg  <= rd_zero_next;
        rd_last_reg  <= rd_last_next;
        fwd_data_reg <= fwd_data_next;
        grp_last_reg <= grp_last_next;
        if (rd_vld_reg)
        begin
            grp_byte_reg[rd_idx_reg] <= copy_byte;
        end
        if (lit_go)
        begin
            ob0_reg       <= in_byte;
            ob1_reg       <= '0;
            ob2_reg       <= '0;
            ob3_reg       <= '0;
            cnt_reg       <= lzwd_pkg::CNT_LIT;
            run_last_reg  <= 1'b1;
            chunk_end_reg <= chunk_last;
        end
        else if (grp_move)
        begin
            ob0_reg       <= grp_byte_reg[0];
            ob1_reg       <= grp_byte_reg[1];
            ob2_reg       <= grp_byte_reg[2];
            ob3_reg       <= grp_byte_reg[3];
            cnt_reg       <= lzwd_pkg::CNT_COPY;
            run_last_reg  <= grp_last_reg;
            chunk_end_reg <= chunk_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte_0  = ob0_reg;
    assign out_byte_1  = ob1_reg;
    assign out_byte_2  = ob2_reg;
    assign out_byte_3  = ob3_reg;
    assign byte_count  = cnt_reg;
    assign last_of_run = run_last_reg;
    assign chunk_end   = chunk_end_reg;

    a_grp_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(grp_full_reg && rd_vld_reg))
        else $error("window read returned into a full group buffer");

    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!grp_full_reg && !rd_vld_reg))
        else $error("input taken while a copy is in flight");

    a_lit_out: assert property (@(posedge clk) disable iff (!rst_n)
        lit_go |=> (out_valid && (byte_count == lzwd_pkg::CNT_LIT)))
        else $error("literal beat missing");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> (wp_reg == '0))
        else $error("fill mark set off the wrap point");

endmodule

`default_nettype wire

>>> dv/lzwd_stream_checker.sv
module lzwd_stream_checker
    import lzwd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                chunk_last,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [BYTE_W-1:0]   out_byte_0,
    input  logic [BYTE_W-1:0]   out_byte_1,
    input  logic [BYTE_W-1:0]   out_byte_2,
    input  logic [BYTE_W-1:0]   out_byte_3,
    input  logic [CNT_W-1:0]    byte_count,
    input  logic                last_of_run,
    input  logic                chunk_end,
    output int                  fail_count,
    output int                  beats_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [GRP_BYTES-1:0][BYTE_W-1:0] data;
        logic [CNT_W-1:0]                 cnt;
        logic                             run_last;
        logic                             end_of_chunk;
    } beat_t;

    beat_t decoded_beats[$];

    logic [BYTE_W-1:0] window [WIN_DEPTH];
    logic [WIN_AW-1:0] wr_pos;
    logic [BYTE_W-1:0] flag_byte;
    logic [REM_W-1:0]  flags_left;
    phase_t            phase;
    logic [1:0]        lit_idx;
    logic [BYTE_W-1:0] ofs_lo;

    task automatic next_token();
        if (flags_left == '0)
        begin
            phase = PH_FLAG;
        end
        else
        begin
            flags_left = flags_left - 1'b1;
            lit_idx = '0;
            phase = flag_byte[flags_left] ? PH_OFS_LO : PH_LIT;
        end
    endtask

    task automatic store_byte(input logic [BYTE_W-1:0] v);
        window[wr_pos] = v;
        wr_pos = wr_pos + 1'b1;
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        beat_t             bt;
        logic [WIN_AW-1:0] back_ofs;
        logic [WIN_AW-1:0] rd_pos;
        int                groups;
        bt = '0;
        case (phase)
            PH_FLAG:
            begin
                flag_byte = b;
                flags_left = FLAGS_PER_BYTE;
                next_token();
            end
            PH_LIT:
            begin
                store_byte(b);
                bt.data[0] = b;
                bt.cnt = CNT_LIT;
                bt.run_last = 1'b1;
                bt.end_of_chunk = last;
                decoded_beats.push_back(bt);
                lit_idx = lit_idx + 1'b1;
                if (lit_idx == '0)
                    next_token();
            end
            PH_OFS_LO:
            begin
                ofs_lo = b;
                phase = PH_OFS_HI;
            end
            default:
            begin
                back_ofs = {b[2:0], ofs_lo};
                groups = int'(b[7:3]) + 1;
                for (int g = 0; g < groups; g++)
                begin
                    for (int k = 0; k < GRP_BYTES; k++)
                    begin
                        // overlapping copies pick up bytes written earlier in this loop
                        rd_pos = wr_pos - back_ofs;
                        bt.data[k] = window[rd_pos];
                        store_byte(window[rd_pos]);
                    end
                    bt.cnt = CNT_COPY;
                    bt.run_last = (g == groups - 1);
                    bt.end_of_chunk = last;
                    decoded_beats.push_back(bt);
                end
                next_token();
            end
        endcase
        if (last)
        begin
            phase = PH_FLAG;
            flags_left = '0;
            lit_idx = '0;
        end
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        beat_t bt;
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
                window[i] = '0;
            wr_pos = '0;
            flag_byte = '0;
            flags_left = '0;
            phase = PH_FLAG;
            lit_idx = '0;
            ofs_lo = '0;
            decoded_beats.delete();
            fail_count = 0;
            beats_owed = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(in_byte, chunk_last);
            if (out_valid && out_ready)
            begin
                if (decoded_beats.size() == 0)
                begin
                    $error("output beat with nothing expected: %h %h %h %h cnt %0d",
                           out_byte_0, out_byte_1, out_byte_2, out_byte_3, byte_count);
                    fail_count++;
                end
                else
                begin
                    bt = decoded_beats.pop_front();
                    check_field("out_byte_0", bt.data[0], out_byte_0);
                    check_field("out_byte_1", bt.data[1], out_byte_1);
                    check_field("out_byte_2", bt.data[2], out_byte_2);
                    check_field("out_byte_3", bt.data[3], out_byte_3);
                    check_field("byte_count", bt.cnt, byte_count);
                    check_field("last_of_run", bt.run_last, last_of_run);
                    check_field("chunk_end", bt.end_of_chunk, chunk_end);
                end
            end
            beats_owed = decoded_beats.size();
        end
    end

endmodule

>>> dv/lz_window_decompressor_test.sv
module lz_window_decompressor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lzwd_pkg::*;

    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte;
    logic                chunk_last;
    logic                out_valid;
    logic                out_ready;
    logic [BYTE_W-1:0]   out_byte_0;
    logic [BYTE_W-1:0]   out_byte_1;
    logic [BYTE_W-1:0]   out_byte_2;
    logic [BYTE_W-1:0]   out_byte_3;
    logic [CNT_W-1:0]    byte_count;
    logic                last_of_run;
    logic                chunk_end;
    int                  fail_count;
    int                  beats_owed;

    int                  cycle_count = 0;
    int                  items_sent = 0;
    bit                  burst = 1'b0;
    bit                  hold_req = 1'b0;
    bit                  hold_done = 1'b0;
    int                  burst_from = -1;

    lz_window_decompressor dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .chunk_last  (chunk_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte_0  (out_byte_0),
        .out_byte_1  (out_byte_1),
        .out_byte_2  (out_byte_2),
        .out_byte_3  (out_byte_3),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .chunk_end   (chunk_end)
    );

    lzwd_stream_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .chunk_last  (chunk_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte_0  (out_byte_0),
        .out_byte_1  (out_byte_1),
        .out_byte_2  (out_byte_2),
        .out_byte_3  (out_byte_3),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .chunk_end   (chunk_end),
        .fail_count  (fail_count),
        .beats_owed  (beats_owed)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[lz_window_decompressor] ERROR");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= rst_n && (burst || $urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        @(negedge clk);
        while (!burst && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        chunk_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (beats_owed != 0)
            @(negedge clk);
    endtask

    task automatic send_random_chunk();
        logic [BYTE_W-1:0] chunk[$];
        logic [BYTE_W-1:0] flags;
        logic [WIN_AW-1:0] back_ofs;
        int                n_flag_bytes;
        int                tokens;
        int                len_m1;
        int                cut;
        if ($urandom_range(0, 7) == 0)
        begin
            // noise: arbitrary bytes with no structure
            repeat ($urandom_range(1, 6))
                chunk.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            n_flag_bytes = ($urandom_range(0, 3) == 0) ? 2 : 1;
            for (int f = 0; f < n_flag_bytes; f++)
            begin
                flags = BYTE_W'($urandom_range(0, 255));
                tokens = (f < n_flag_bytes - 1) ? 8 : $urandom_range(1, 8);
                chunk.push_back(flags);
                for (int t = 0; t < tokens; t++)
                begin
                    if (flags[7 - t])
                    begin
                        // mostly short copies, now and then a full-length one
                        len_m1 = ($urandom_range(0, 19) == 0) ? 31 : $urandom_range(0, 3);
                        back_ofs = $urandom_range(0, 1) ? WIN_AW'($urandom_range(1, 8))
                                                        : WIN_AW'($urandom_range(0, WIN_DEPTH - 1));
                        chunk.push_back(back_ofs[7:0]);
                        chunk.push_back({len_m1[4:0], back_ofs[10:8]});
                    end
                    else
                    begin
                        repeat (GRP_BYTES)
                            chunk.push_back(BYTE_W'($urandom_range(0, 255)));
                    end
                end
            end
            // truncated chunk, may end mid-token
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, chunk.size());
                while (chunk.size() > cut)
                    void'(chunk.pop_back());
            end
        end
        foreach (chunk[i])
            send_byte(chunk[i], i == chunk.size() - 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        chunk_last = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // flags: literal group, copy, literal group cut short by end of chunk
        send_byte(8'h40, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h01, 1'b0);     // distance 1: overlapping repeat
        send_byte(8'h00, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);
        // all copies: distance zero and max distance at max length, a short copy, then half a copy
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hf8, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h05, 1'b1);
        // chunk ending on its flag byte
        send_byte(8'h00, 1'b1);
        // chunk ending on a copy's second byte
        send_byte(8'h80, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h0a, 1'b1);
        // full literal group ending the chunk
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b1);

        drain();

        while (items_sent < RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= 40)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!burst && burst_from < 0 && items_sent >= 90)
            begin
                burst = 1'b1;
                burst_from = items_sent;
            end
            else if (burst && items_sent >= burst_from + 40)
            begin
                burst = 1'b0;
            end
            send_random_chunk();
        end
        burst = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[lz_window_decompressor] OK");
        else
            $display("[lz_window_decompressor] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_parser.sv
hw/rtl/lz_window_decompressor.sv
dv/lzwd_stream_checker.sv
dv/lz_window_decompressor_test.sv
